// ----- sv/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and defaults of the delta timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int DefCapacity  = 16;
  localparam int DefDelayBits = 16;

  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindRemove = 2'd1;
  localparam logic [1:0] KindTick   = 2'd2;
  localparam logic [1:0] KindPop    = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  handle;
    logic [15:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_handle;
    logic [1:0] status;
    logic [4:0] count;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic insert;
    logic remove;
    logic pop;
    logic dec;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/delta_timer_queue.sv -----
// ----------------------------------------------------------------------------
// delta_timer_queue
// Sleep queue of task handles kept in wake order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command (insert, remove by handle, tick, pop expired head) is taken on
//   cmd_i at a rising edge where start is high and busy is low. busy stays
//   high for the one execute cycle that follows. The result is registered
//   onto rsp_o at the end of the execute cycle, flagged by done_o for
//   exactly one cycle; the receiver cannot hold it off. A new command can be
//   taken in the same cycle the previous result is shown. In the execute
//   cycle every cell compares its wake time and handle in parallel, and on
//   an insert, remove or pop the slots from the affected one to the tail
//   shift by one slot toward or away from the head.
//   Each cell keeps the absolute wake time of its entry; a tick lowers all of
//   them at once unless the head is zero, the same as lowering the head delta.
//   Reset empties the queue (count zero); slot contents are not cleared and
//   are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_timer_queue
  import dtq_pkg::*;
#(
  parameter int CAPACITY   = DefCapacity,
  parameter int DELAY_BITS = DefDelayBits
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  wire cmd_t  cmd_i,
  output logic       done_o,
  output rsp_t       rsp_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                  state_q, state_d;
  cmd_t                  cmd_q;
  logic [CntW-1:0]       count_q, count_d;
  logic                  done_q;
  rsp_t                  rsp_q, rsp_d;

  logic [DELAY_BITS-1:0] new_time;
  logic                  exec;
  logic                  full, empty, head_zero, found;
  cell_ctrl_t            ctrl;

  logic [7:0]            cell_handle [CAPACITY];
  logic [DELAY_BITS-1:0] cell_time   [CAPACITY];
  logic [CAPACITY-1:0]   cell_ge;
  logic [CAPACITY:0]     cell_found;

  assign new_time  = DELAY_BITS'(cmd_q.delay);
  assign exec      = (state_q == StExec);
  assign full      = (count_q >= CntW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign head_zero = (cell_time[0] == '0);
  assign found     = cell_found[CAPACITY];

  always_comb begin
    ctrl.insert = exec && (cmd_q.kind == KindInsert) && !full;
    ctrl.remove = exec && (cmd_q.kind == KindRemove);
    ctrl.pop    = exec && (cmd_q.kind == KindPop) && !empty && head_zero;
    ctrl.dec    = exec && (cmd_q.kind == KindTick) && !empty && !head_zero;
  end

  assign cell_found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  valid;
    logic [7:0]            left_handle, right_handle;
    logic [DELAY_BITS-1:0] left_time, right_time;
    logic                  prev_ge;

    assign valid = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_handle = cell_handle[i];
      assign left_time   = cell_time[i];
      assign prev_ge     = 1'b0;
    end else begin : g_body
      assign left_handle = cell_handle[i-1];
      assign left_time   = cell_time[i-1];
      assign prev_ge     = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_handle = cell_handle[i];
      assign right_time   = cell_time[i];
    end else begin : g_next
      assign right_handle = cell_handle[i+1];
      assign right_time   = cell_time[i+1];
    end

    dtq_cell #(
      .DELAY_BITS (DELAY_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .valid_i        (valid),
      .new_handle_i   (cmd_q.handle),
      .new_time_i     (new_time),
      .left_handle_i  (left_handle),
      .left_time_i    (left_time),
      .right_handle_i (right_handle),
      .right_time_i   (right_time),
      .prev_ge_i      (prev_ge),
      .found_i        (cell_found[i]),
      .handle_o       (cell_handle[i]),
      .time_o         (cell_time[i]),
      .ge_o           (cell_ge[i]),
      .found_o        (cell_found[i+1])
    );
  end

  always_comb begin
    state_d           = state_q;
    count_d           = count_q;
    rsp_d             = rsp_q;
    rsp_d.out_handle  = '0;
    rsp_d.status      = StatusOk;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
        case (cmd_q.kind)
          KindInsert: begin
            if (full) begin
              rsp_d.status = StatusFull;
            end else begin
              count_d = count_q + CntW'(1);
            end
          end
          KindRemove: begin
            if (found) begin
              rsp_d.out_handle = cmd_q.handle;
              count_d          = count_q - CntW'(1);
            end else begin
              rsp_d.status = StatusNotFound;
            end
          end
          KindTick: begin
          end
          KindPop: begin
            if (ctrl.pop) begin
              rsp_d.out_handle = cell_handle[0];
              count_d          = count_q - CntW'(1);
            end else begin
              rsp_d.status = StatusNotFound;
            end
          end
          default: begin
          end
        endcase
        rsp_d.count = 5'(count_d);
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= exec;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = exec;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ----- sv/dtq_cell.sv -----
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted row: holds a handle and its absolute wake time.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_cell
  import dtq_pkg::*;
#(
  parameter int DELAY_BITS = DefDelayBits
) (
  input  wire                    clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire                    valid_i,
  input  wire  [7:0]             new_handle_i,
  input  wire  [DELAY_BITS-1:0]  new_time_i,
  input  wire  [7:0]             left_handle_i,
  input  wire  [DELAY_BITS-1:0]  left_time_i,
  input  wire  [7:0]             right_handle_i,
  input  wire  [DELAY_BITS-1:0]  right_time_i,
  input  wire                    prev_ge_i,
  input  wire                    found_i,
  output logic [7:0]             handle_o,
  output logic [DELAY_BITS-1:0]  time_o,
  output logic                   ge_o,
  output logic                   found_o
);

  logic [7:0]            handle_q, handle_d;
  logic [DELAY_BITS-1:0] time_q, time_d;
  logic                  hit;

  // empty slots count as later than anything, so the first one takes a new entry
  assign ge_o     = !valid_i || (time_q >= new_time_i);
  assign hit      = valid_i && ctrl_i.remove && (handle_q == new_handle_i);
  assign found_o  = found_i || hit;
  assign handle_o = handle_q;
  assign time_o   = time_q;

  always_comb begin
    handle_d = handle_q;
    time_d   = time_q;
    if (ctrl_i.insert) begin
      if (prev_ge_i) begin
        handle_d = left_handle_i;
        time_d   = left_time_i;
      end else if (ge_o) begin
        handle_d = new_handle_i;
        time_d   = new_time_i;
      end
    end else if (ctrl_i.pop || (ctrl_i.remove && found_o)) begin
      handle_d = right_handle_i;
      time_d   = right_time_i;
    end else if (ctrl_i.dec) begin
      // every live time is at least the head time, so no wrap
      time_d = time_q - DELAY_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    time_q   <= time_d;
  end

endmodule

`default_nettype wire

// ----- sv/dtq_checker.sv -----
// ----------------------------------------------------------------------------
// dtq_port_checks
// Port-level timing checks of the delta timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_port_checks
  import dtq_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire cmd_t cmd_i,
  input wire       done_o,
  input wire rsp_t rsp_o
);

  // an accepted transaction occupies exactly one execute cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy && done_o)
    else $error("execute cycle did not end with a result");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a command");

  a_fail_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == StatusFull || rsp_o.status == StatusNotFound)
      |-> rsp_o.out_handle == 8'd0)
    else $error("failed command reported a handle");

endmodule

bind delta_timer_queue dtq_port_checks u_dtq_port_checks (.*);

`default_nettype wire
